FILE: design/cia_pkg.sv
// ----------------------------------------------------------------------------
// cia_pkg - shared types and opcodes for the checked integer ALU
// Opcode names and the classified word passed from front to back.
// ----------------------------------------------------------------------------
package cia_pkg;

   localparam int KIND_WIDTH = 5;

   typedef enum logic [KIND_WIDTH-1:0] {
      OP_ADD  = 5'd0,  OP_SUB  = 5'd1,  OP_MUL  = 5'd2,  OP_DIV  = 5'd3,
      OP_MOD  = 5'd4,  OP_OR   = 5'd5,  OP_XOR  = 5'd6,  OP_AND  = 5'd7,
      OP_SHIFT = 5'd8, OP_LAND = 5'd9,  OP_LOR  = 5'd10, OP_LXOR = 5'd11,
      OP_LNOT = 5'd12, OP_LT   = 5'd13, OP_GT   = 5'd14, OP_EQ   = 5'd15,
      OP_LE   = 5'd16, OP_GE   = 5'd17, OP_NE   = 5'd18, OP_ABS  = 5'd19,
      OP_SIGN = 5'd20, OP_INC  = 5'd21, OP_DEC  = 5'd22
   } kind_type;

   // class of a word once decoded by the front end
   typedef enum logic [1:0] {
      CLS_SIMPLE = 2'd0,
      CLS_MUL    = 2'd1,
      CLS_DIV    = 2'd2
   } cls_type;

endpackage

FILE: design/checked_integer_alu_unit.sv
// A request word passes a queue slot, the magnitude stage, the product stage,
// DATA_WIDTH divide stages and the output register before it is offered as a
// result word. Throughput: one word per cycle unless rsp_stall holds the
// pipeline; the divider is a DATA_WIDTH-stage restoring pipeline, one
// quotient bit per stage, beside a single-stage multiplier.
// Reset: synchronous, active high; clears all valid bits and queue pointers.
// ----------------------------------------------------------------------------
// checked_integer_alu_unit - checked integer ALU, top level
// Front register classifies words, a two-entry queue decouples it from
// the back-end execution pipeline that forms value and flags.
// ----------------------------------------------------------------------------
module checked_integer_alu_unit #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [cia_pkg::KIND_WIDTH-1:0] req_kind,
   input  logic signed [DATA_WIDTH-1:0]  req_operand_a,
   input  logic signed [DATA_WIDTH-1:0]  req_operand_b,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [DATA_WIDTH-1:0]  rsp_value,
   output logic                          rsp_overflow_flag,
   output logic                          rsp_div_zero_flag
);
   import cia_pkg::*;

   // queue word: kind, class, a, b
   localparam int QW = KIND_WIDTH + 2 + 2*DATA_WIDTH;

   logic                   f_valid, f_stall;
   logic [KIND_WIDTH-1:0]  f_kind;
   cls_type                f_cls;
   logic [DATA_WIDTH-1:0]  f_a, f_b;
   logic                   q_valid, q_stall;
   logic [QW-1:0]          q_word;
   logic [KIND_WIDTH-1:0]  q_kind;
   logic [1:0]             q_cls;
   logic [DATA_WIDTH-1:0]  q_a, q_b;

   cia_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_kind, .req_operand_a,
      .req_operand_b, .f_valid, .f_stall, .f_kind, .f_cls, .f_a, .f_b
   );

   cia_queue #(.WORD_WIDTH(QW)) u_queue (
      .clock, .reset,
      .in_valid  (f_valid),
      .in_stall  (f_stall),
      .in_word   ({f_kind, f_cls, f_a, f_b}),
      .out_valid (q_valid),
      .out_stall (q_stall),
      .out_word  (q_word)
   );

   // class travels with the word; the back end decodes kind fully
   assign {q_kind, q_cls, q_a, q_b} = q_word;

   cia_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
      .clock, .reset,
      .q_valid (q_valid && (q_cls != 2'd3)),
      .q_stall, .q_kind, .q_a, .q_b,
      .rsp_valid, .rsp_stall, .rsp_value, .rsp_overflow_flag, .rsp_div_zero_flag
   );
endmodule

FILE: design/cia_front.sv
// ----------------------------------------------------------------------------
// cia_front - input register and classifier
// Takes request words, decodes the opcode class and holds one word.
// ----------------------------------------------------------------------------
module cia_front #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [cia_pkg::KIND_WIDTH-1:0] req_kind,
   input  logic signed [DATA_WIDTH-1:0]  req_operand_a,
   input  logic signed [DATA_WIDTH-1:0]  req_operand_b,
   output logic                          f_valid,
   input  logic                          f_stall,
   output logic [cia_pkg::KIND_WIDTH-1:0] f_kind,
   output cia_pkg::cls_type              f_cls,
   output logic [DATA_WIDTH-1:0]         f_a,
   output logic [DATA_WIDTH-1:0]         f_b
);
   import cia_pkg::*;

   logic valid_ff;
   logic [KIND_WIDTH-1:0] kind_ff;
   cls_type cls_ff, cls_in;
   logic [DATA_WIDTH-1:0] a_ff, b_ff;
   logic take;

   assign req_stall = valid_ff && f_stall;
   assign take      = req_valid && !req_stall;

   always_comb begin
      case (req_kind)
         OP_MUL:         cls_in = CLS_MUL;
         OP_DIV, OP_MOD: cls_in = CLS_DIV;
         default:        cls_in = CLS_SIMPLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= req_valid;
      end
      if (take) begin
         kind_ff <= req_kind;
         cls_ff  <= cls_in;
         a_ff    <= req_operand_a;
         b_ff    <= req_operand_b;
      end
   end

   assign f_valid = valid_ff;
   assign f_kind  = kind_ff;
   assign f_cls   = cls_ff;
   assign f_a     = a_ff;
   assign f_b     = b_ff;
endmodule

FILE: design/cia_queue.sv
// ----------------------------------------------------------------------------
// cia_queue - two-entry queue between front and back
// Decouples the stall of the back end from the front end.
// ----------------------------------------------------------------------------
module cia_queue #(
   parameter int WORD_WIDTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_stall,
   input  logic [WORD_WIDTH-1:0] in_word,
   output logic                  out_valid,
   input  logic                  out_stall,
   output logic [WORD_WIDTH-1:0] out_word
);
   logic [WORD_WIDTH-1:0] mem_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic push, pop;

   assign in_stall  = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_word  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) mem_ff[wr_ptr_ff] <= in_word;
   end
endmodule

FILE: design/cia_back.sv
// ----------------------------------------------------------------------------
// cia_back - execution pipeline
// Stage 0 takes magnitudes, stage 1 the product, stages 2..W+1 a restoring
// divide one bit per stage, then result and flags go to the output register.
// ----------------------------------------------------------------------------
module cia_back #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   output logic                          q_stall,
   input  logic [cia_pkg::KIND_WIDTH-1:0] q_kind,
   input  logic [DATA_WIDTH-1:0]         q_a,
   input  logic [DATA_WIDTH-1:0]         q_b,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [DATA_WIDTH-1:0]  rsp_value,
   output logic                          rsp_overflow_flag,
   output logic                          rsp_div_zero_flag
);
   import cia_pkg::*;

   localparam int W     = DATA_WIDTH;
   localparam int DEPTH = W + 1;
   localparam int SW    = $clog2(W) + 1;

   typedef struct packed {
      logic [KIND_WIDTH-1:0] kind;
      logic [W-1:0]          a;
      logic [W-1:0]          b;
      logic [W-1:0]          rem;
      logic [W-1:0]          quo;
      logic [W-1:0]          dvd;
      logic [W-1:0]          dvs;
      logic [2*W-1:0]        prod;
   } stage_type;

   logic      valid_ff [DEPTH+1];
   stage_type st_ff    [DEPTH+1];
   stage_type st_in    [DEPTH+1];
   logic      adv;

   // whole pipeline moves together; it holds while its last stage is valid and rsp_stall is high
   assign adv     = !(valid_ff[DEPTH] && rsp_stall);
   assign q_stall = !adv;

   function automatic logic [W-1:0] mag(input logic [W-1:0] v);
      mag = v[W-1] ? (~v + 1'b1) : v;
   endfunction

   always_comb begin
      st_in[0]      = '0;
      st_in[0].kind = q_kind;
      st_in[0].a    = q_a;
      st_in[0].b    = q_b;
      st_in[0].dvd  = mag(q_a);
      st_in[0].dvs  = mag(q_b);
   end

   // stage 1: magnitude product (one W x W multiply)
   always_comb begin
      st_in[1]      = st_ff[0];
      st_in[1].prod = st_ff[0].dvd * st_ff[0].dvs;
   end

   // stages 2..W+1: one restoring divide step each, MSB first
   for (genvar s = 2; s <= DEPTH; s++) begin : g_div
      always_comb begin
         logic [W:0] trial;
         st_in[s] = st_ff[s-1];
         trial = {st_ff[s-1].rem, st_ff[s-1].dvd[W-1-(s-2)]} - {1'b0, st_ff[s-1].dvs};
         if (!trial[W]) begin
            st_in[s].rem = trial[W-1:0];
            st_in[s].quo = {st_ff[s-1].quo[W-2:0], 1'b1};
         end else begin
            st_in[s].rem = {st_ff[s-1].rem[W-2:0], st_ff[s-1].dvd[W-1-(s-2)]};
            st_in[s].quo = {st_ff[s-1].quo[W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= DEPTH; i++) valid_ff[i] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= q_valid;
         for (int i = 1; i <= DEPTH; i++) valid_ff[i] <= valid_ff[i-1];
      end
      if (adv) begin
         for (int i = 0; i <= DEPTH; i++) st_ff[i] <= st_in[i];
      end
   end

   // final result formation from the last stage
   stage_type       f;
   logic [W-1:0]    a, b, v, sum, dif, sh_n;
   logic            sa, sb, ovf, dz, a_nz, b_nz, lt, gt, negp, minm1;
   logic [SW-1:0]   amt;
   logic [W-1:0]    min_v;

   always_comb begin
      f     = st_ff[DEPTH];
      a     = f.a;
      b     = f.b;
      sa    = a[W-1];
      sb    = b[W-1];
      a_nz  = (a != '0);
      b_nz  = (b != '0);
      lt    = $signed(a) < $signed(b);
      gt    = $signed(b) < $signed(a);
      sum   = a + b;
      dif   = a - b;
      min_v = {1'b1, {(W-1){1'b0}}};
      minm1 = (a == min_v) && (b == '1);
      negp  = (sa != sb) && a_nz && b_nz;
      sh_n  = ~b + 1'b1;
      amt   = '0;
      v     = '0;
      ovf   = 1'b0;
      dz    = 1'b0;
      case (kind_type'(f.kind))
         OP_ADD: begin
            v = sum; ovf = (sa == sb) && (sum[W-1] != sa);
         end
         OP_SUB: begin
            v = dif; ovf = (sa != sb) && (dif[W-1] != sa);
         end
         OP_MUL: begin
            v   = negp ? (~f.prod[W-1:0] + 1'b1) : f.prod[W-1:0];
            ovf = (f.prod[2*W-1:W] != '0) ||
                  (negp ? (f.prod[W-1:0] > min_v) : f.prod[W-1]);
         end
         OP_DIV: begin
            if (minm1) begin
               ovf = 1'b1;
            end else if (!b_nz) begin
               dz = 1'b1;
            end else begin
               v = (sa != sb) ? (~f.quo + 1'b1) : f.quo;
            end
         end
         OP_MOD: begin
            if (minm1) begin
               v = W'(1); ovf = 1'b1;
            end else if (b_nz) begin
               v = sa ? (~f.rem + 1'b1) : f.rem;
            end
         end
         OP_OR:  v = a | b;
         OP_XOR: v = a ^ b;
         OP_AND: v = a & b;
         OP_SHIFT: begin
            if (!sb) begin
               if (b >= W'(W)) v = '0;
               else begin
                  amt = b[SW-1:0];
                  v   = a << amt;
               end
            end else if (sh_n == '0 || sh_n >= W'(W)) begin
               v = sa ? '1 : '0;
            end else begin
               amt = sh_n[SW-1:0];
               v   = W'($signed(a) >>> amt);
            end
         end
         OP_LAND: v = W'(a_nz && b_nz);
         OP_LOR:  v = W'(a_nz || b_nz);
         OP_LXOR: v = W'(a_nz != b_nz);
         OP_LNOT: v = W'(!b_nz);
         OP_LT:   v = W'(lt);
         OP_GT:   v = W'(gt);
         OP_EQ:   v = W'(a == b);
         OP_LE:   v = W'(!gt);
         OP_GE:   v = W'(!lt);
         OP_NE:   v = W'(a != b);
         OP_ABS:  v = sb ? (~b + 1'b1) : b;
         OP_SIGN: v = sb ? '1 : W'(b_nz);
         OP_INC:  v = b + 1'b1;
         OP_DEC:  v = b - 1'b1;
         default: v = '0;
      endcase
   end

   // output register
   logic            out_valid_ff;
   logic [W-1:0]    out_value_ff;
   logic            out_ovf_ff, out_dz_ff;
   logic            out_take;

   assign out_take = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_take) begin
         out_valid_ff <= valid_ff[DEPTH] && adv;
      end
      if (out_take) begin
         out_value_ff <= v;
         out_ovf_ff   <= ovf;
         out_dz_ff    <= dz;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_value         = out_value_ff;
   assign rsp_overflow_flag = out_ovf_ff;
   assign rsp_div_zero_flag = out_dz_ff;
endmodule

FILE: test/checked_integer_alu_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// checked_integer_alu_checker - result predictor and comparator
// Watches both channels, computes the expected word for each accepted
// request and compares it field by field with the returned word.
// ----------------------------------------------------------------------------
module checked_integer_alu_checker #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [cia_pkg::KIND_WIDTH-1:0] req_kind,
   input  logic signed [DATA_WIDTH-1:0]   req_operand_a,
   input  logic signed [DATA_WIDTH-1:0]   req_operand_b,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic signed [DATA_WIDTH-1:0]   rsp_value,
   input  logic                           rsp_overflow_flag,
   input  logic                           rsp_div_zero_flag,
   output int                             fail_count,
   output int                             pending_count
);
   import cia_pkg::*;

   localparam logic [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic [DATA_WIDTH-1:0] ALL_ONES = '1;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] value;
      logic                  ovf;
      logic                  dz;
   } alu_word_type;

   alu_word_type expected_words[$];

   function automatic alu_word_type alu_predict(logic [KIND_WIDTH-1:0] kind,
                                                logic [DATA_WIDTH-1:0] a,
                                                logic [DATA_WIDTH-1:0] b);
      alu_word_type r;
      logic signed [2*DATA_WIDTH:0] prod;
      logic signed [DATA_WIDTH:0] wa, wb;
      logic [DATA_WIDTH-1:0] ma, mb, q;
      logic signed [DATA_WIDTH-1:0] sa, sb;
      r = '0;
      sa = a;
      sb = b;
      wa = sa;
      wb = sb;
      ma = a[DATA_WIDTH-1] ? -a : a;
      mb = b[DATA_WIDTH-1] ? -b : b;
      case (kind)
         OP_ADD: begin
            r.value = a + b;
            r.ovf = (a[DATA_WIDTH-1] == b[DATA_WIDTH-1]) &&
                    (r.value[DATA_WIDTH-1] != a[DATA_WIDTH-1]);
         end
         OP_SUB: begin
            r.value = a - b;
            r.ovf = (a[DATA_WIDTH-1] != b[DATA_WIDTH-1]) &&
                    (r.value[DATA_WIDTH-1] != a[DATA_WIDTH-1]);
         end
         OP_MUL: begin
            prod = wa * wb;
            r.value = prod[DATA_WIDTH-1:0];
            r.ovf = (prod != $signed(r.value));
         end
         OP_DIV: begin
            if (a == MIN_VAL && b == ALL_ONES) r.ovf = 1'b1;
            else if (b == 0) r.dz = 1'b1;
            else begin
               q = ma / mb;
               r.value = (a[DATA_WIDTH-1] != b[DATA_WIDTH-1]) ? -q : q;
            end
         end
         OP_MOD: begin
            if (a == MIN_VAL && b == ALL_ONES) begin
               r.value = 1;
               r.ovf = 1'b1;
            end else if (b != 0) begin
               q = ma % mb;
               r.value = a[DATA_WIDTH-1] ? -q : q;
            end
         end
         OP_OR:  r.value = a | b;
         OP_XOR: r.value = a ^ b;
         OP_AND: r.value = a & b;
         OP_SHIFT: begin
            if (sb >= DATA_WIDTH || sb <= -DATA_WIDTH)
               r.value = (sb < 0 && a[DATA_WIDTH-1]) ? ALL_ONES : '0;
            else if (sb >= 0) r.value = a << sb;
            else r.value = sa >>> (-sb);
         end
         OP_LAND: r.value = (a != 0 && b != 0);
         OP_LOR:  r.value = (a != 0 || b != 0);
         OP_LXOR: r.value = ((a != 0) != (b != 0));
         OP_LNOT: r.value = (b == 0);
         OP_LT:   r.value = (sa < sb);
         OP_GT:   r.value = (sa > sb);
         OP_EQ:   r.value = (a == b);
         OP_LE:   r.value = (sa <= sb);
         OP_GE:   r.value = (sa >= sb);
         OP_NE:   r.value = (a != b);
         OP_ABS:  r.value = mb;
         OP_SIGN: r.value = b[DATA_WIDTH-1] ? ALL_ONES : (b != 0);
         OP_INC:  r.value = b + 1;
         OP_DEC:  r.value = b - 1;
         default: r.value = '0;
      endcase
      return r;
   endfunction

   // one update of each count per edge, however many fields disagree
   always @(posedge clock) begin
      alu_word_type want;
      int errs;
      errs = 0;
      if (reset) begin
         expected_words.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $error("unexpected result word value=%0h", rsp_value);
               errs++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_value !== want.value) begin
                  $error("value: expected %0h actual %0h", want.value, rsp_value);
                  errs++;
               end
               if (rsp_overflow_flag !== want.ovf) begin
                  $error("overflow_flag: expected %0b actual %0b", want.ovf,
                         rsp_overflow_flag);
                  errs++;
               end
               if (rsp_div_zero_flag !== want.dz) begin
                  $error("div_zero_flag: expected %0b actual %0b", want.dz,
                         rsp_div_zero_flag);
                  errs++;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_words.push_back(alu_predict(req_kind, req_operand_a, req_operand_b));
      end
      if (errs != 0) fail_count <= fail_count + errs;
      pending_count <= expected_words.size();
   end

   initial begin
      fail_count = 0;
      pending_count = 0;
   end

endmodule

FILE: test/checked_integer_alu_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// checked_integer_alu_unit_test - top-level test of the checked integer ALU
// Directed corner words, then random words with random gaps and stalls;
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module checked_integer_alu_unit_test;
   import cia_pkg::*;

   localparam int DW = 32;
   localparam int LATENCY = DW + 6;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_WORDS = 1950;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [KIND_WIDTH-1:0] req_kind = '0;
   logic signed [DW-1:0] req_operand_a = '0;
   logic signed [DW-1:0] req_operand_b = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [DW-1:0] rsp_value;
   logic rsp_overflow_flag;
   logic rsp_div_zero_flag;
   int fail_count;
   int pending_count;
   int idle_cycles = 0;
   bit long_hold = 1'b0;  // receiver hold-off request, set by the sender

   always #4 clock = ~clock;

   checked_integer_alu_unit #(.DATA_WIDTH(DW)) u_top (.*);

   checked_integer_alu_checker #(.DATA_WIDTH(DW)) u_checker (.*);

   // watchdog: cycles with nothing accepted on either side
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // receiver: random stalls, plus one long hold-off so the block backs up
   initial begin
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            long_hold = 1'b0;
         end
         n = gap_length();
         if ($urandom_range(0, 3) == 0) n = 0;  // stretches with no stalls
         rsp_stall <= (n != 0);
         repeat (n > 0 ? n : 1) @(posedge clock);
         rsp_stall <= 1'b0;
         @(posedge clock);
      end
   end

   // operand picker: corners often, random otherwise
   function automatic logic [DW-1:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return {1'b1, {(DW-1){1'b0}}};
         1: return {1'b0, {(DW-1){1'b1}}};
         2: return '1;
         3: return '0;
         4: return $urandom_range(0, 40) - 20;   // small, shift counts
         5: return $urandom_range(0, 70) - 35;
         6: return $urandom_range(0, 65535) - 32768;
         default: return $urandom();
      endcase
   endfunction

   task automatic send_word(logic [KIND_WIDTH-1:0] kind, logic [DW-1:0] a,
                            logic [DW-1:0] b, bit paced);
      int gap;
      gap = paced ? gap_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};
   localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};

   initial begin
      int k;
      int settle;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners
      send_word(OP_ADD, MAXV, 1, 0);
      send_word(OP_SUB, MINV, 1, 0);
      send_word(OP_MUL, MINV, '1, 0);
      send_word(OP_MUL, 32'h10000, 32'hFFFF8000, 0);
      send_word(OP_DIV, MINV, '1, 0);         // MIN by -1
      send_word(OP_MOD, MINV, '1, 0);
      send_word(OP_DIV, 7, 0, 0);             // divide by zero
      send_word(OP_MOD, 7, 0, 0);
      send_word(OP_DIV, -7, 2, 0);            // truncation toward zero
      send_word(OP_MOD, -7, 2, 0);
      send_word(OP_SHIFT, -5, 32, 0);         // left saturation
      send_word(OP_SHIFT, -5, -32, 0);        // right saturation, negative a
      send_word(OP_SHIFT, 0, MINV, 0);        // huge right shift of zero
      send_word(OP_SHIFT, 32'h12345678, 0, 0);
      send_word(OP_SHIFT, MINV, -31, 0);
      send_word(OP_ABS, 0, MINV, 0);
      send_word(OP_INC, 0, MAXV, 0);
      send_word(OP_DEC, 0, MINV, 0);
      send_word(OP_SIGN, 0, -3, 0);
      for (k = OP_OR; k <= 31; k++)           // every remaining code, unused too
         send_word(k[KIND_WIDTH-1:0], 5, -5, 0);
      drain_results();

      // random words; partway the receiver holds off while we keep sending
      for (k = 0; k < RANDOM_WORDS; k++) begin
         if (k == 600) long_hold = 1'b1;
         if (k == 1200) drain_results();        // sender pause until empty
         send_word(KIND_WIDTH'($urandom_range(0, 31)), pick_operand(), pick_operand(), 1);
      end
      drain_results();

      settle = 0;
      while (settle < 2 * LATENCY) begin
         @(posedge clock);
         settle++;
      end
      if (fail_count == 0 && pending_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
